@@ design/pset_pkg.sv @@
package pset_pkg;

	localparam int MAX_ENTRIES_DEF = 16;

	localparam logic [2:0] CMD_INSERT = 3'd0;
	localparam logic [2:0] CMD_DELETE = 3'd1;
	localparam logic [2:0] CMD_SEARCH = 3'd2;
	localparam logic [2:0] CMD_CLEAR  = 3'd3;
	localparam logic [2:0] CMD_SORT   = 3'd4;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_FULL      = 2'd1;
	localparam logic [1:0] STAT_RANGE     = 2'd2;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic [2:0]         command;
		logic signed [15:0] new_priority;
		logic [15:0]        entry_id;
		logic [3:0]         entry_index;
	} pset_req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [3:0]         found_index;
		logic [15:0]        echoed_id;
		logic [4:0]         entry_count;
		logic signed [15:0] top_priority;
		logic signed [15:0] top_below_window;
	} pset_rsp_t;

	typedef struct packed {
		logic signed [15:0] pri;
		logic [15:0]        id;
	} pset_entry_t;

endpackage

@@ design/priority_sorted_entry_table_top.sv @@
// channel   signals                    handshake
// request   start, busy, req           taken when start is high and busy is low
// result    done, rsp                  one-cycle strobe on done, cannot be held off
// config    cfg_valid, cfg_ready, cfg_data   written when valid and ready are both high
//
// Entries sit in one single-port-read memory; every walk reads one entry a cycle.
// Insert, delete and search walk part of the table, then every request ends in a summary walk
// over all entries (S_SUMINIT, S_SUM) before the result strobe; clear does only the summary walk.
// Sort runs bubble passes, at most count - 1 passes, then the summary walk.
// Reset clears the entry count and the window register; the table needs no clearing.
// busy is high from the cycle after a request until the result strobe.
module priority_sorted_entry_table_top #(
	parameter int MAX_ENTRIES = pset_pkg::MAX_ENTRIES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  pset_pkg::pset_req_t req,
	output logic                done,
	output pset_pkg::pset_rsp_t rsp,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [15:0]         cfg_data
);

	logic signed [15:0] window_q;

	// window register only changes between requests
	assign cfg_ready = !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			window_q <= cfg_data;
		end
	end

	pset_core #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.window (window_q),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

endmodule

@@ design/pset_core.sv @@
module pset_core #(
	parameter int MAX_ENTRIES = pset_pkg::MAX_ENTRIES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  pset_pkg::pset_req_t req,
	input  logic signed [15:0]  window,
	output logic                busy,
	output logic                done,
	output pset_pkg::pset_rsp_t rsp
);

	localparam int AW   = $clog2(MAX_ENTRIES);
	localparam int CW   = $clog2(MAX_ENTRIES + 1);
	localparam int CMPW = (CW > 4) ? CW : 4;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_INS     = 3'd1;
	localparam logic [2:0] S_DEL     = 3'd2;
	localparam logic [2:0] S_SRCH    = 3'd3;
	localparam logic [2:0] S_SORT    = 3'd4;
	localparam logic [2:0] S_SUMINIT = 3'd5;
	localparam logic [2:0] S_SUM     = 3'd6;

	pset_pkg::pset_entry_t mem [MAX_ENTRIES];

	logic [2:0]            state_q;
	pset_pkg::pset_req_t   req_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         ptr_q;
	logic                  more_q;
	logic [CW-1:0]         lim_q;
	logic                  swapped_q;
	pset_pkg::pset_entry_t carry_q;
	logic [1:0]            status_q;
	logic [3:0]            found_q;
	logic [15:0]           echo_q;
	logic signed [15:0]    top_q;
	logic signed [15:0]    below_q;
	logic                  brk_q;
	logic                  done_q;
	pset_pkg::pset_rsp_t   rsp_q;

	logic                  rv_s1;
	logic [AW-1:0]         ra_s1;
	pset_pkg::pset_entry_t rd_data_s1;

	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	pset_pkg::pset_entry_t wr_data;
	pset_pkg::pset_entry_t new_entry;
	logic                  ins_stop;
	logic                  srch_hit;
	logic                  walk_end;
	logic                  carry_gt;
	logic [CW-1:0]         lim_w;
	logic [CW-1:0]         ptr_inc;
	logic [CMPW-1:0]       idx_w;
	logic [CMPW-1:0]       cnt_w;

	assign new_entry = '{pri: req_q.new_priority, id: req_q.entry_id};
	assign walk_end  = !more_q && !rv_s1;
	assign ins_stop  = rv_s1 ? (rd_data_s1.pri < req_q.new_priority) : !more_q;
	assign srch_hit  = rv_s1 && (rd_data_s1.id == req_q.entry_id);
	assign carry_gt  = (carry_q.pri > rd_data_s1.pri) ||
		((carry_q.pri == rd_data_s1.pri) && (carry_q.id > rd_data_s1.id));
	assign lim_w     = (state_q == S_SORT) ? lim_q : count_q;
	assign ptr_inc   = ptr_q + CW'(1);
	assign idx_w     = CMPW'(req.entry_index);
	assign cnt_w     = CMPW'(count_q);
	assign rd_addr   = ptr_q[AW-1:0];

	always_comb begin
		rd_en   = 1'b0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = rd_data_s1;
		case (state_q)
			S_INS: begin
				// walk down from the top, moving each entry of equal or larger priority up one place
				rd_en = more_q && !ins_stop;
				if (rv_s1) begin
					wr_en   = 1'b1;
					wr_addr = ra_s1 + AW'(1);
					wr_data = ins_stop ? new_entry : rd_data_s1;
				end else if (!more_q) begin
					wr_en   = 1'b1;
					wr_data = new_entry;
				end
			end
			S_DEL: begin
				rd_en = more_q;
				if (rv_s1) begin
					wr_en   = 1'b1;
					wr_addr = ra_s1 - AW'(1);
				end
			end
			S_SRCH: begin
				rd_en = more_q && !srch_hit;
			end
			S_SORT: begin
				// carry holds the largest entry seen so far in this pass
				rd_en = more_q;
				if (rv_s1 && (ra_s1 != '0)) begin
					wr_en   = 1'b1;
					wr_addr = ra_s1 - AW'(1);
					wr_data = carry_gt ? rd_data_s1 : carry_q;
				end else if (walk_end) begin
					wr_en   = 1'b1;
					wr_addr = AW'(lim_q - CW'(1));
					wr_data = carry_q;
				end
			end
			S_SUM: begin
				rd_en = more_q;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
			ra_s1      <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			more_q  <= 1'b0;
			rv_s1   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			rv_s1  <= rd_en;
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q    <= req;
						status_q <= pset_pkg::STAT_OK;
						found_q  <= '0;
						echo_q   <= '0;
						state_q  <= S_SUMINIT;
						case (req.command)
							pset_pkg::CMD_INSERT: begin
								if (count_q == CW'(MAX_ENTRIES)) begin
									status_q <= pset_pkg::STAT_FULL;
								end else begin
									ptr_q   <= count_q - CW'(1);
									more_q  <= (count_q != '0);
									state_q <= S_INS;
								end
							end
							pset_pkg::CMD_DELETE: begin
								if (idx_w >= cnt_w) begin
									status_q <= pset_pkg::STAT_RANGE;
								end else begin
									ptr_q   <= CW'(idx_w + CMPW'(1));
									more_q  <= (idx_w + CMPW'(1)) < cnt_w;
									state_q <= S_DEL;
								end
							end
							pset_pkg::CMD_SEARCH: begin
								ptr_q   <= '0;
								more_q  <= (count_q != '0);
								state_q <= S_SRCH;
							end
							pset_pkg::CMD_CLEAR: begin
								count_q <= '0;
							end
							pset_pkg::CMD_SORT: begin
								if (count_q > CW'(1)) begin
									lim_q     <= count_q;
									swapped_q <= 1'b0;
									ptr_q     <= '0;
									more_q    <= 1'b1;
									state_q   <= S_SORT;
								end
							end
							default: begin
								state_q <= S_SUMINIT;
							end
						endcase
					end
				end
				S_INS: begin
					if (rd_en) begin
						ptr_q  <= ptr_q - CW'(1);
						more_q <= (ptr_q != '0);
					end
					if (ins_stop) begin
						count_q <= count_q + CW'(1);
						echo_q  <= req_q.entry_id;
						state_q <= S_SUMINIT;
					end
				end
				S_DEL: begin
					if (rd_en) begin
						ptr_q  <= ptr_inc;
						more_q <= ptr_inc < lim_w;
					end
					if (walk_end) begin
						count_q <= count_q - CW'(1);
						state_q <= S_SUMINIT;
					end
				end
				S_SRCH: begin
					if (rd_en) begin
						ptr_q  <= ptr_inc;
						more_q <= ptr_inc < lim_w;
					end
					if (srch_hit) begin
						found_q <= 4'(ra_s1);
						state_q <= S_SUMINIT;
					end else if (walk_end) begin
						status_q <= pset_pkg::STAT_NOT_FOUND;
						state_q  <= S_SUMINIT;
					end
				end
				S_SORT: begin
					if (rd_en) begin
						ptr_q  <= ptr_inc;
						more_q <= ptr_inc < lim_w;
					end
					if (rv_s1) begin
						if (ra_s1 == '0) begin
							carry_q <= rd_data_s1;
						end else if (carry_gt) begin
							swapped_q <= 1'b1;
						end else begin
							carry_q <= rd_data_s1;
						end
					end
					if (walk_end) begin
						// stop once a pass makes no swap or only one pair is left
						if (!swapped_q || (lim_q == CW'(2))) begin
							state_q <= S_SUMINIT;
						end else begin
							lim_q     <= lim_q - CW'(1);
							swapped_q <= 1'b0;
							ptr_q     <= '0;
							more_q    <= 1'b1;
						end
					end
				end
				S_SUMINIT: begin
					ptr_q   <= '0;
					more_q  <= (count_q != '0);
					top_q   <= '0;
					below_q <= '0;
					brk_q   <= 1'b0;
					state_q <= S_SUM;
				end
				S_SUM: begin
					if (rd_en) begin
						ptr_q  <= ptr_inc;
						more_q <= ptr_inc < lim_w;
					end
					if (rv_s1) begin
						top_q <= rd_data_s1.pri;
						if (!brk_q) begin
							if (rd_data_s1.pri < window) begin
								below_q <= rd_data_s1.pri;
							end else begin
								brk_q <= 1'b1;
							end
						end
					end
					if (walk_end) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_SUM) && walk_end) begin
			rsp_q.status           <= status_q;
			rsp_q.found_index      <= found_q;
			rsp_q.echoed_id        <= echo_q;
			rsp_q.entry_count      <= 5'(count_q);
			rsp_q.top_priority     <= top_q;
			rsp_q.top_below_window <= below_q;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not make the block busy");

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without preceding work");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && wr_en) |-> (rd_addr != wr_addr))
		else $error("read and write to the same entry in one cycle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ENTRIES))
		else $error("entry count beyond table size");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
		((count_q == $past(count_q) + CW'(1)) || (count_q == $past(count_q) - CW'(1)) ||
		(count_q == '0)))
		else $error("entry count moved by more than one");

endmodule
